// ----- sv/tcce_pkg.sv -----
// Package for the text console cursor engine: command codes, character codes,
// config register indexes and the queue entry types shared by all modules.
// No dependencies.
package tcce_pkg;

  // Draw command kinds on the result channel
  typedef enum logic [1:0] {
    CMD_GLYPH  = 2'd0,
    CMD_INVERT = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_kind_t;

  // Control characters
  localparam logic [7:0] CHAR_BS = 8'd8;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  // Config register indexes
  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_COLUMNS = 2'd1;
  localparam logic [1:0] REG_ROWS    = 2'd2;

  localparam int CFG_DATA_W = 9;

  // One draw command before pixel expansion
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  glyph;
    logic [7:0]  col;
    logic [6:0]  row;
  } draw_cmd_t;

  // All commands caused by one byte; last_idx is the index of the final one
  typedef struct packed {
    logic [1:0]      last_idx;
    draw_cmd_t [2:0] cmds;
  } byte_entry_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic        valid;
    byte_entry_t entry;
  } q_head_t;

endpackage

// ----- sv/tcce_front.sv -----
// Front end: config registers, cursor state and byte classification.
// Builds one queue entry per accepted byte. Depends on tcce_pkg.
module tcce_front #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [7:0]                   in_char_code,
  output logic                         push,
  output tcce_pkg::byte_entry_t        push_entry
);

  localparam int COL_LIM_I = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam int ROW_LIM_I = (MAX_ROWS < 128) ? MAX_ROWS : 128;
  localparam logic [8:0] COL_LIM = 9'((COL_LIM_I < 1) ? 1 : COL_LIM_I);
  localparam logic [7:0] ROW_LIM = 8'((ROW_LIM_I < 1) ? 1 : ROW_LIM_I);

  logic       enable_r;
  logic [8:0] columns_r;
  logic [7:0] rows_r;
  logic [7:0] col_r, col_nxt;
  logic [6:0] row_r, row_nxt;

  logic [8:0] ncols, ncols_m1;
  logic [7:0] nrows, nrows_m1;
  logic [7:0] c_sat, c_bs;
  logic [6:0] r_sat, r_nl, bottom;
  logic [7:0] r_inc;
  logic [8:0] c_inc;
  logic       scroll;
  tcce_pkg::byte_entry_t entry;

  // Write config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      columns_r <= 9'd80;
      rows_r    <= 8'd30;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcce_pkg::REG_ENABLE:  enable_r  <= cfg_wdata[0];
        tcce_pkg::REG_COLUMNS: columns_r <= cfg_wdata;
        tcce_pkg::REG_ROWS:    rows_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign push = in_valid && !in_stall && enable_r;

  // Clamp grid size and saturate cursor into the grid
  always_comb begin
    ncols = columns_r;
    if (ncols == 9'd0) ncols = 9'd1;
    if (ncols > COL_LIM) ncols = COL_LIM;
    nrows = rows_r;
    if (nrows == 8'd0) nrows = 8'd1;
    if (nrows > ROW_LIM) nrows = ROW_LIM;
    ncols_m1 = ncols - 9'd1;
    nrows_m1 = nrows - 8'd1;
    bottom   = nrows_m1[6:0];
    c_sat    = ({1'b0, col_r} >= ncols) ? ncols_m1[7:0] : col_r;
    r_sat    = ({1'b0, row_r} >= nrows) ? bottom : row_r;
    r_inc    = {1'b0, r_sat} + 8'd1;
    scroll   = (r_inc >= nrows);
    r_nl     = scroll ? bottom : r_inc[6:0];
    c_inc    = {1'b0, c_sat} + 9'd1;
    c_bs     = (c_sat == 8'd0) ? 8'd0 : c_sat - 8'd1;
  end

  // Classify the byte and build its command list
  always_comb begin
    entry.last_idx = 2'd1;
    entry.cmds[0]  = '{tcce_pkg::CMD_INVERT, 8'd0, c_sat, r_sat};
    entry.cmds[1]  = '{tcce_pkg::CMD_INVERT, 8'd0, c_sat, r_sat};
    entry.cmds[2]  = '{tcce_pkg::CMD_INVERT, 8'd0, c_sat, r_sat};
    col_nxt = c_sat;
    row_nxt = r_sat;
    priority if (in_char_code == tcce_pkg::CHAR_CR) begin
      // invert twice, cursor stays
    end else if (in_char_code == tcce_pkg::CHAR_BS) begin
      entry.cmds[1] = '{tcce_pkg::CMD_INVERT, 8'd0, c_bs, r_sat};
      col_nxt = c_bs;
    end else if (in_char_code == tcce_pkg::CHAR_LF || c_inc >= ncols) begin
      // new line, with scroll at the bottom row
      if (in_char_code != tcce_pkg::CHAR_LF) begin
        entry.cmds[0] = '{tcce_pkg::CMD_GLYPH, in_char_code, c_sat, r_sat};
      end
      if (scroll) begin
        entry.last_idx = 2'd2;
        entry.cmds[1]  = '{tcce_pkg::CMD_SCROLL, 8'd0, 8'd0, bottom};
        entry.cmds[2]  = '{tcce_pkg::CMD_INVERT, 8'd0, 8'd0, r_nl};
      end else begin
        entry.cmds[1]  = '{tcce_pkg::CMD_INVERT, 8'd0, 8'd0, r_nl};
      end
      col_nxt = 8'd0;
      row_nxt = r_nl;
    end else begin
      entry.cmds[0] = '{tcce_pkg::CMD_GLYPH, in_char_code, c_sat, r_sat};
      entry.cmds[1] = '{tcce_pkg::CMD_INVERT, 8'd0, c_inc[7:0], r_sat};
      col_nxt = c_inc[7:0];
    end
  end

  assign push_entry = entry;

  // Advance the cursor on every enabled byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 7'd0;
    end else if (push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- sv/tcce_queue.sv -----
// Two-entry queue of per-byte command lists between front and back end.
// Depends on tcce_pkg.
module tcce_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tcce_pkg::byte_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output tcce_pkg::q_head_t     head
);

  tcce_pkg::byte_entry_t entries_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.entry = entries_r[rd_ptr_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_entry;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- sv/tcce_back.sv -----
// Back end: walks the queue head into the output register one command per
// cycle while not stalled, adds pixel coordinates and the last mark. Depends on tcce_pkg.
module tcce_back #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcce_pkg::q_head_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_command,
  output logic [7:0]        out_glyph,
  output logic [7:0]        out_cell_column,
  output logic [6:0]        out_cell_row,
  output logic [10:0]       out_pixel_x,
  output logic [10:0]       out_pixel_y,
  output logic              out_last
);

  logic [1:0]  idx_r;
  logic        valid_r;
  logic [1:0]  command_r;
  logic [7:0]  glyph_r, col_out_r;
  logic [6:0]  row_out_r;
  logic [10:0] px_r, py_r;
  logic        last_r;

  logic                load, is_last;
  tcce_pkg::draw_cmd_t sel;

  assign load    = head.valid && (!valid_r || !out_stall);
  assign sel     = head.entry.cmds[idx_r];
  assign is_last = (idx_r == head.entry.last_idx);
  assign pop     = load && is_last;

  // Step through the commands of the head entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      if (load) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
    end
  end

  // Load the output register; hold it while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      command_r <= sel.kind;
      glyph_r   <= sel.glyph;
      col_out_r <= sel.col;
      row_out_r <= sel.row;
      px_r      <= {3'd0, sel.col} * 11'(GLYPH_WIDTH);
      py_r      <= {4'd0, sel.row} * 11'(GLYPH_HEIGHT);
      last_r    <= is_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_command     = command_r;
  assign out_glyph       = glyph_r;
  assign out_cell_column = col_out_r;
  assign out_cell_row    = row_out_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_last        = last_r;

endmodule

// ----- sv/text_console_cursor_engine.sv -----
// Text console cursor engine, top level.
// Instantiates tcce_front, tcce_queue and tcce_back; depends on tcce_pkg.
//
// Usage: write enable (index 0), columns (1) and rows (2) through the cfg_
// port while idle. Send character bytes on the in_ channel (valid/stall).
// Each enabled byte yields two or three draw commands on the out_ channel,
// one transaction per cycle while out_stall is low, the final one marked by
// out_last. With enable clear, bytes are accepted and dropped without commands.
// With the queue and output register empty, the first command of a byte is
// written into the queue at its accepting edge and then into the output register.
// Throughput: the back end emits one command per cycle while out_stall is low,
// two or three per byte; the front end accepts a byte every cycle while the
// two-entry command queue has room.
// Reset: cursor at column 0, row 0; enable 0, 80 columns, 30 rows; queue
// and output register empty.
// Receiver stall: the output register holds its transaction, the back end
// stops, the queue fills and in_stall rises once both entries are taken.
module text_console_cursor_engine #(
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_ROWS     = 128,
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command,
  output logic [7:0]  out_glyph,
  output logic [7:0]  out_cell_column,
  output logic [6:0]  out_cell_row,
  output logic [10:0] out_pixel_x,
  output logic [10:0] out_pixel_y,
  output logic        out_last
);

  logic                  push, pop, full;
  tcce_pkg::byte_entry_t push_entry;
  tcce_pkg::q_head_t     head;

  assign in_stall = full;

  tcce_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (full),
    .in_char_code(in_char_code),
    .push        (push),
    .push_entry  (push_entry)
  );

  tcce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (full),
    .head      (head)
  );

  tcce_back #(
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_command    (out_command),
    .out_glyph      (out_glyph),
    .out_cell_column(out_cell_column),
    .out_cell_row   (out_cell_row),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last       (out_last)
  );

endmodule

// ----- sv/tcce_checker.sv -----
// Port-level checker for the text console cursor engine, bound to the top.
// Depends on tcce_pkg.
module tcce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_command,
  input logic [7:0]  out_glyph,
  input logic        out_last
);

  // Hold a stalled transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command) && $stable(out_last))
    else $error("stalled output transaction changed");

  // Drive glyph zero on non-draw commands
  a_glyph_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command != tcce_pkg::CMD_GLYPH |-> out_glyph == 8'd0)
    else $error("glyph nonzero on non-draw command");

  // End every byte with a cursor invert
  a_last_invert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_command == tcce_pkg::CMD_INVERT)
    else $error("last command is not a cursor invert");

  // Follow a scroll with a cursor invert
  a_scroll_then_invert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_command == tcce_pkg::CMD_SCROLL
    |=> out_valid && out_command == tcce_pkg::CMD_INVERT && out_last)
    else $error("scroll not followed by final invert");

  // Clear output valid after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_command(out_command),
  .out_glyph  (out_glyph),
  .out_last   (out_last)
);
